// ----- rtl/pairwise_mvdr_spectrum_accumulator_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the pairwise MVDR spectrum accumulator
// Small wrappers that keep the concurrent checks short and uniform.
// ----------------------------------------------------------------------------
`ifndef PAIRWISE_MVDR_SPECTRUM_ACCUMULATOR_DEFINES_SVH
`define PAIRWISE_MVDR_SPECTRUM_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PMSA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pmsa assertion failed");

// Next-cycle implication, disabled during reset.
`define PMSA_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pmsa assertion failed");

`endif

// ----- rtl/pmsa_pkg.sv -----
// ----------------------------------------------------------------------------
// pmsa_pkg
// Shared constants for the pairwise MVDR spectrum accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pmsa_pkg;

  // Default table geometry.
  localparam int ANGLES_DEF = 16;
  localparam int BINS_DEF   = 256;
  localparam int PAIRS_DEF  = 8;

  // Register reset value.
  localparam logic [3:0] PAIR_COUNT_RST = 4'd8;

  // Saturation limits of a signed 32-bit value.
  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  // Divider geometry: dividend magnitude is the numerator shifted up by 16.
  localparam int DIV_NUM_W = 50;
  localparam int DIV_DEN_W = 36;
  localparam int DIV_W     = DIV_NUM_W + 16;

  // Command codes: write and accumulate.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_ACCUM = 1'b1;

endpackage

// ----- rtl/pairwise_mvdr_spectrum_accumulator.sv -----
// ----------------------------------------------------------------------------
// Pairwise MVDR spectrum accumulator
// Steering table plus a sequenced multiplier and restoring divider that sum
// the MVDR terms of several microphone pairs into one spectrum value.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  item      in         item_valid/item_stall command, indexes, covariances,
//                                             steering entry
//  result    out        result_valid/         spectrum, divide_fault
//                       result_stall
//  cfg       in         cfg_we                cfg_wdata (pair_count)
//
//  A write item leaves item_stall low. An accumulate item holds item_stall high
//  while it makes five passes through the one shared 32x32 multiplier, then
//  up to two 66-step restoring divisions through the one shared divider, one
//  quotient bit a cycle. After reset the steering table is cleared one entry a
//  cycle (ANGLES*BINS*PAIRS entries, 32768 by default); no item is taken
//  meanwhile. A result waits in the output register; the last pair of a sum
//  holds there until that register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pairwise_mvdr_spectrum_accumulator_defines.svh"

module pairwise_mvdr_spectrum_accumulator
  import pmsa_pkg::*;
#(
  parameter int ANGLES = ANGLES_DEF,
  parameter int BINS   = BINS_DEF,
  parameter int PAIRS  = PAIRS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic               command,
  input  logic [3:0]         angle_index,
  input  logic [7:0]         bin_index,
  input  logic [2:0]         pair_index,
  input  logic signed [31:0] cov_ii_real,
  input  logic signed [31:0] cov_jj_real,
  input  logic signed [31:0] cov_ij_real,
  input  logic signed [31:0] cov_ij_imag,
  input  logic signed [31:0] cov_ji_real,
  input  logic signed [31:0] cov_ji_imag,
  input  logic signed [15:0] steer_real,
  input  logic signed [15:0] steer_imag,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [31:0] spectrum,
  output logic               divide_fault,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_wdata
);

  localparam int DEPTH = ANGLES * BINS * PAIRS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LOAD, S_MUL, S_ACC, S_DSET, S_DIV, S_DFIN, S_TERM, S_OUT
  } state_t;

  state_t state;

  // Configuration and sum state.
  logic [3:0]         pair_count;
  logic signed [31:0] run_sum;
  logic               fault_seen;

  // Captured item.
  logic signed [31:0] r11, r22, r12r, r12i, r21r, r21i;
  logic signed [15:0] sr, si;
  logic [2:0]         pidx;
  logic               hit_q;
  logic signed [32:0] tr;

  // Multiplier sequencing.
  logic [2:0]         mstep;
  logic signed [31:0] ma, mb;
  logic signed [63:0] prod;
  logic signed [63:0] prod_sh;
  logic signed [49:0] nacc;
  logic signed [48:0] dacc;
  logic signed [48:0] dsh;
  logic signed [35:0] dval;

  // Divider.
  logic               phase;
  logic [DIV_W-1:0]   dv_n;
  logic [35:0]        dv_d;
  logic [35:0]        dv_r;
  logic [32:0]        dv_q;
  logic               dv_ovf;
  logic               dv_neg;
  logic [6:0]         dv_cnt;
  logic [37:0]        dv_diff;
  logic               dv_ge;
  logic signed [31:0] qres;
  logic signed [31:0] num;
  logic signed [31:0] term;
  logic signed [32:0] d2;
  logic signed [49:0] su_num;
  logic signed [35:0] su_den;
  logic [49:0]        su_nmag;
  logic [35:0]        su_dmag;

  // Sum and last-pair decision.
  logic signed [32:0] sum_wide;
  logic signed [31:0] sum_sat;
  logic [7:0]         cnt_eff;
  logic               is_last;

  // Memory.
  logic [31:0]        mem [DEPTH];
  logic [31:0]        rdata;
  logic [AW-1:0]      clr_addr;
  logic [AW-1:0]      in_idx;
  logic               in_hit;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [31:0]        mem_wdata;
  logic               accept;
  logic               out_free;

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;

  // Steering table address of the incoming item.
  assign in_hit = (32'(angle_index) < ANGLES) && (32'(bin_index) < BINS) &&
                  (32'(pair_index) < PAIRS);
  assign in_idx = AW'((32'(angle_index) * BINS + 32'(bin_index)) * PAIRS +
                      32'(pair_index));

  // One write port shared by the clearing pass and the write command.
  assign mem_we    = (state == S_CLEAR) || (accept && (command == CMD_WRITE) && in_hit);
  assign mem_waddr = (state == S_CLEAR) ? clr_addr : in_idx;
  assign mem_wdata = (state == S_CLEAR) ? 32'd0 : {steer_imag, steer_real};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[in_idx];
  end

  // Multiplier operand selection by step.
  always_comb begin
    case (mstep)
      3'd0:    begin ma = r11;  mb = r22; end
      3'd1:    begin ma = r12r; mb = r21r; end
      3'd2:    begin ma = r12i; mb = r21i; end
      3'd3:    begin ma = r12r; mb = 32'(sr); end
      default: begin ma = r12i; mb = 32'(si); end
    endcase
  end

  assign prod_sh = prod >>> 16;

  // First divisor: tr - 2 * ((r12r*sr - r12i*si) >> 15).
  assign dsh  = dacc >>> 15;
  assign dval = 36'(tr) - 36'(dsh <<< 1);

  // Second divisor: tr/2 - num.
  assign d2 = 33'(tr >>> 1) - 33'(num);

  // Operands of the divider setup, chosen by which division is next.
  assign su_num  = phase ? 50'(num) : nacc;
  assign su_den  = phase ? 36'(d2) : dval;
  assign su_nmag = su_num[49] ? 50'(-su_num) : 50'(su_num);
  assign su_dmag = su_den[35] ? 36'(-su_den) : 36'(su_den);

  // One restoring division step.
  assign dv_diff = {1'b0, dv_r, dv_n[DIV_W-1]} - {2'b00, dv_d};
  assign dv_ge   = !dv_diff[37];

  // Signed, saturated quotient.
  always_comb begin
    if (dv_neg) begin
      if (dv_ovf || dv_q[32] || (dv_q[31] && (|dv_q[30:0]))) begin
        qres = S32_MIN;
      end else begin
        qres = 32'(-$signed(dv_q));
      end
    end else begin
      if (dv_ovf || dv_q[32] || dv_q[31]) begin
        qres = S32_MAX;
      end else begin
        qres = $signed(dv_q[31:0]);
      end
    end
  end

  // Running sum with saturation.
  assign sum_wide = 33'(run_sum) + 33'(term);
  always_comb begin
    if (sum_wide > 33'(S32_MAX)) begin
      sum_sat = S32_MAX;
    end else if (sum_wide < 33'(S32_MIN)) begin
      sum_sat = S32_MIN;
    end else begin
      sum_sat = 32'(sum_wide);
    end
  end

  // Effective pair count, clamped to 1..PAIRS.
  always_comb begin
    if (pair_count == 4'd0) begin
      cnt_eff = 8'd1;
    end else if (32'(pair_count) > PAIRS) begin
      cnt_eff = 8'(PAIRS);
    end else begin
      cnt_eff = 8'(pair_count);
    end
  end
  assign is_last = (8'(pidx) + 8'd1) == cnt_eff;

  // Sequencer, datapath registers and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      pair_count   <= PAIR_COUNT_RST;
      run_sum      <= '0;
      fault_seen   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        pair_count <= cfg_wdata;
      end
      // The output state reloads the register itself when it is taken.
      if (result_valid && !result_stall && (state != S_OUT)) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (accept && (command == CMD_ACCUM)) begin
            r11   <= cov_ii_real;
            r22   <= cov_jj_real;
            r12r  <= cov_ij_real;
            r12i  <= cov_ij_imag;
            r21r  <= cov_ji_real;
            r21i  <= cov_ji_imag;
            pidx  <= pair_index;
            hit_q <= in_hit;
            state <= S_LOAD;
          end
        end

        // Table read data arrives; zero steering outside the table.
        S_LOAD: begin
          sr    <= hit_q ? $signed(rdata[15:0]) : 16'sd0;
          si    <= hit_q ? $signed(rdata[31:16]) : 16'sd0;
          tr    <= 33'(r11) + 33'(r22);
          mstep <= 3'd0;
          state <= S_MUL;
        end

        S_MUL: begin
          prod  <= ma * mb;
          state <= S_ACC;
        end

        S_ACC: begin
          case (mstep)
            3'd0:    nacc <= 50'(prod_sh);
            3'd1:    nacc <= nacc - 50'(prod_sh);
            3'd2:    nacc <= nacc + 50'(prod_sh);
            3'd3:    dacc <= 49'(prod);
            default: dacc <= dacc - 49'(prod);
          endcase
          if (mstep == 3'd4) begin
            phase <= 1'b0;
            state <= S_DSET;
          end else begin
            mstep <= mstep + 3'd1;
            state <= S_MUL;
          end
        end

        // Zero divisor saturates the term; otherwise load the divider.
        S_DSET: begin
          if (su_den == 36'sd0) begin
            fault_seen <= 1'b1;
            term       <= su_num[49] ? S32_MIN : S32_MAX;
            state      <= S_TERM;
          end else begin
            dv_n   <= {su_nmag, 16'd0};
            dv_d   <= su_dmag;
            dv_r   <= '0;
            dv_q   <= '0;
            dv_ovf <= 1'b0;
            dv_neg <= su_num[49] ^ su_den[35];
            dv_cnt <= '0;
            state  <= S_DIV;
          end
        end

        S_DIV: begin
          dv_r   <= dv_ge ? dv_diff[35:0] : {dv_r[34:0], dv_n[DIV_W-1]};
          dv_q   <= {dv_q[31:0], dv_ge};
          dv_ovf <= dv_ovf | dv_q[32];
          dv_n   <= {dv_n[DIV_W-2:0], 1'b0};
          dv_cnt <= dv_cnt + 7'd1;
          if (dv_cnt == 7'(DIV_W - 1)) begin
            state <= S_DFIN;
          end
        end

        S_DFIN: begin
          if (!phase) begin
            num   <= qres;
            phase <= 1'b1;
            state <= S_DSET;
          end else begin
            term  <= qres;
            state <= S_TERM;
          end
        end

        S_TERM: begin
          run_sum <= sum_sat;
          state   <= is_last ? S_OUT : S_IDLE;
        end

        // Hand the sum to the output register once it is free.
        S_OUT: begin
          if (out_free) begin
            spectrum     <= run_sum;
            divide_fault <= fault_seen;
            result_valid <= 1'b1;
            run_sum      <= '0;
            fault_seen   <= 1'b0;
            state        <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // A new result only ever comes out of the output state.
  `PMSA_ASSERT_IMP(a_result_src, clk, rst, $rose(result_valid), $past(state) == S_OUT)
  // Emitting a result clears the sum and the fault flag.
  `PMSA_ASSERT_NXT(a_sum_clear, clk, rst, (state == S_OUT) && out_free,
                   (run_sum == 32'sd0) && !fault_seen)
  // A zero divisor always raises the fault flag.
  `PMSA_ASSERT_NXT(a_zero_fault, clk, rst, (state == S_DSET) && (su_den == 36'sd0),
                   fault_seen)

endmodule
